[src/ets_pkg.sv]
// Package for the exhaustive tour search core: sizes, register codes,
// sequencer states and the cost saturation helper.
// No dependencies; used by exhaustive_tour_search_core and its testbench.
`default_nettype none

package ets_pkg;

    // Sizing
    localparam int MAX_CITIES  = 8;
    localparam int WEIGHT_BITS = 16;
    localparam int MIN_CITIES  = 2;
    localparam int CITY_W      = $clog2(MAX_CITIES);
    localparam int CNT_W       = $clog2(MAX_CITIES + 1);
    localparam int ADDR_W      = 2 * CITY_W;
    localparam int MAT_DEPTH   = 1 << ADDR_W;
    localparam int CC_W        = 4;
    localparam int COST_W      = 19;
    localparam int CFG_IDX_W   = 1;

    // Cost range and reset ceiling
    localparam int COST_MAX      = 262143;
    localparam int COST_MIN      = -262144;
    localparam int CEILING_RESET = 32000;

    // Exact tour sum: room for MAX_CITIES weights, never narrower than the cost
    localparam int SUM_RAW = WEIGHT_BITS + $clog2(MAX_CITIES) + 1;
    localparam int SUM_W   = (SUM_RAW > COST_W) ? SUM_RAW : COST_W + 1;

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(COST_MAX);
    localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(COST_MIN);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_CEILING = 1'b1;

    // Input item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COST,
        ST_DRAIN,
        ST_CMP,
        ST_PLOAD,
        ST_FINDP,
        ST_FINDJ,
        ST_REV_A,
        ST_REV_B,
        ST_EMIT
    } t_state;

    // Clamp the exact sum into the signed cost range
    function automatic logic signed [COST_W-1:0] sat_cost(input logic signed [SUM_W-1:0] v);
        logic signed [COST_W-1:0] r;
        if (v > SUM_HI) begin
            r = COST_W'(COST_MAX);
        end else if (v < SUM_LO) begin
            r = COST_W'(COST_MIN);
        end else begin
            r = v[COST_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/exhaustive_tour_search_core.sv]
// Exhaustive tour search core: weight matrix load and brute-force tour walk.
// Depends on ets_pkg and ets_ram.
//
// Load item: accepted while idle, and the core stays ready for the next item.
// Solve item: (n-1)! tours for n cities. Each tour is summed through the single
// matrix read port, then permuted to the next tour on the one shared tour read
// port. Then n result items (one if no tour beats the ceiling), one per cycle
// while the sink is ready.
// Reset (synchronous, active low): sequencer idle, city_count 8, ceiling 32000;
// the weight matrix is not cleared.
`default_nettype none

module exhaustive_tour_search_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [ets_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [ets_pkg::COST_W-1:0]            i_cfg_data,
    // input items
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_kind,
    input  wire logic [ets_pkg::CITY_W-1:0]            i_from_city,
    input  wire logic [ets_pkg::CITY_W-1:0]            i_to_city,
    input  wire logic signed [ets_pkg::WEIGHT_BITS-1:0] i_weight,
    // result items
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [ets_pkg::COST_W-1:0]          o_best_cost,
    output logic [ets_pkg::CITY_W-1:0]                 o_city,
    output logic                                       o_found,
    output logic                                       o_last
);

    localparam int CITY_W = ets_pkg::CITY_W;
    localparam int CNT_W  = ets_pkg::CNT_W;
    localparam int NC     = ets_pkg::MAX_CITIES;

    // Configuration
    logic [CNT_W-1:0]                 r_ncity;
    logic signed [ets_pkg::COST_W-1:0] r_ceiling;
    logic [ets_pkg::CC_W-1:0]         w_cc;

    // Sequencer state
    ets_pkg::t_state                  r_state, n_state;
    logic [CITY_W-1:0]                r_tour [NC];
    logic [CITY_W-1:0]                n_tour [NC];
    logic [CITY_W-1:0]                r_best_tour [NC];
    logic [CITY_W-1:0]                n_best_tour [NC];
    logic signed [ets_pkg::COST_W-1:0] r_best, n_best;
    logic signed [ets_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic                             r_found, n_found;
    logic [CNT_W-1:0]                 r_k, n_k;
    logic [CNT_W-1:0]                 r_lo, n_lo;
    logic [CNT_W-1:0]                 r_hi, n_hi;
    logic [CITY_W-1:0]                r_hold, n_hold;
    logic [CITY_W-1:0]                r_prev, n_prev;
    logic                             r_rd_vld, n_rd_vld;

    // Shared tour read port and matrix port
    logic [CITY_W-1:0]                w_tidx;
    logic [CITY_W-1:0]                w_trd;
    logic [CITY_W-1:0]                w_cur;
    logic signed [ets_pkg::COST_W-1:0] w_cost;
    logic [CNT_W-1:0]                 w_nlast;
    logic                             w_load_we;
    logic [ets_pkg::ADDR_W-1:0]       w_raddr;
    logic [ets_pkg::WEIGHT_BITS-1:0]  w_rdata;
    logic signed [ets_pkg::WEIGHT_BITS-1:0] w_wt;

    assign w_cc    = i_cfg_data[ets_pkg::CC_W-1:0];
    assign w_nlast = r_ncity - CNT_W'(1);
    assign w_wt    = w_rdata;
    assign w_cost  = ets_pkg::sat_cost(r_sum);

    // Configuration registers; city count is clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncity   <= CNT_W'(NC);
            r_ceiling <= ets_pkg::COST_W'(ets_pkg::CEILING_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ets_pkg::CFG_CITY_COUNT: begin
                    if (w_cc < ets_pkg::CC_W'(ets_pkg::MIN_CITIES)) begin
                        r_ncity <= CNT_W'(ets_pkg::MIN_CITIES);
                    end else if (w_cc > ets_pkg::CC_W'(NC)) begin
                        r_ncity <= CNT_W'(NC);
                    end else begin
                        r_ncity <= CNT_W'(w_cc);
                    end
                end
                ets_pkg::CFG_COST_CEILING: r_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Matrix write on a load item with an in-range address
    assign w_load_we = (r_state == ets_pkg::ST_IDLE) && i_in_valid
                       && (i_kind == ets_pkg::KIND_LOAD)
                       && ({1'b0, i_from_city} < (CITY_W + 1)'(NC))
                       && ({1'b0, i_to_city} < (CITY_W + 1)'(NC));

    ets_ram #(
        .WIDTH (ets_pkg::WEIGHT_BITS),
        .DEPTH (ets_pkg::MAT_DEPTH)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr ({i_from_city, i_to_city}),
        .i_wdata (i_weight),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // One tour read index per cycle, chosen by state
    always_comb begin
        unique case (r_state) inside
            ets_pkg::ST_FINDJ,
            ets_pkg::ST_REV_B: w_tidx = r_hi[CITY_W-1:0];
            ets_pkg::ST_REV_A: w_tidx = r_lo[CITY_W-1:0];
            default:           w_tidx = r_k[CITY_W-1:0];
        endcase
    end
    assign w_trd = r_tour[w_tidx];

    // Edge endpoint: the closing edge returns to city 0
    assign w_cur   = (r_k == r_ncity) ? '0 : w_trd;
    assign w_raddr = {r_prev, w_cur};

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_tour      = r_tour;
        n_best_tour = r_best_tour;
        n_best      = r_best;
        n_sum       = r_sum;
        n_found     = r_found;
        n_k         = r_k;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_hold      = r_hold;
        n_prev      = r_prev;
        n_rd_vld    = 1'b0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        // accumulate the weight read in the previous cycle
        if (r_rd_vld) begin
            n_sum = r_sum + ets_pkg::SUM_W'(w_wt);
        end

        unique case (r_state)
            ets_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && (i_kind == ets_pkg::KIND_SOLVE)) begin
                    for (int i = 0; i < NC; i++) begin
                        n_tour[i] = CITY_W'(i);
                    end
                    n_best  = r_ceiling;
                    n_found = 1'b0;
                    n_k     = CNT_W'(1);
                    n_prev  = '0;
                    n_sum   = '0;
                    n_state = ets_pkg::ST_COST;
                end
            end
            // issue one edge read per cycle
            ets_pkg::ST_COST: begin
                n_rd_vld = 1'b1;
                n_prev   = w_cur;
                if (r_k == r_ncity) begin
                    n_state = ets_pkg::ST_DRAIN;
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end
            ets_pkg::ST_DRAIN: n_state = ets_pkg::ST_CMP;
            // keep strictly cheaper tours only
            ets_pkg::ST_CMP: begin
                if (w_cost < r_best) begin
                    n_best      = w_cost;
                    n_best_tour = r_tour;
                    n_found     = 1'b1;
                end
                n_k     = w_nlast;
                n_state = ets_pkg::ST_PLOAD;
            end
            ets_pkg::ST_PLOAD: begin
                n_hold  = w_trd;
                n_k     = r_k - CNT_W'(1);
                n_state = ets_pkg::ST_FINDP;
            end
            // scan down for the pivot (never position 0)
            ets_pkg::ST_FINDP: begin
                if (r_k == '0) begin
                    n_k     = '0;
                    n_state = ets_pkg::ST_EMIT;
                end else if (w_trd < r_hold) begin
                    n_lo    = r_k;
                    n_hold  = w_trd;
                    n_hi    = w_nlast;
                    n_state = ets_pkg::ST_FINDJ;
                end else begin
                    n_hold = w_trd;
                    n_k    = r_k - CNT_W'(1);
                end
            end
            // rightmost entry above the pivot, then swap
            ets_pkg::ST_FINDJ: begin
                if (w_trd > r_hold) begin
                    n_tour[r_lo[CITY_W-1:0]] = w_trd;
                    n_tour[r_hi[CITY_W-1:0]] = r_hold;
                    n_lo    = r_lo + CNT_W'(1);
                    n_hi    = w_nlast;
                    n_state = ets_pkg::ST_REV_A;
                end else begin
                    n_hi = r_hi - CNT_W'(1);
                end
            end
            // reverse the suffix, one swap per pass through REV_A and REV_B
            ets_pkg::ST_REV_A: begin
                if (r_lo >= r_hi) begin
                    n_k     = CNT_W'(1);
                    n_prev  = '0;
                    n_sum   = '0;
                    n_state = ets_pkg::ST_COST;
                end else begin
                    n_hold  = w_trd;
                    n_state = ets_pkg::ST_REV_B;
                end
            end
            ets_pkg::ST_REV_B: begin
                n_tour[r_lo[CITY_W-1:0]] = w_trd;
                n_tour[r_hi[CITY_W-1:0]] = r_hold;
                n_lo    = r_lo + CNT_W'(1);
                n_hi    = r_hi - CNT_W'(1);
                n_state = ets_pkg::ST_REV_A;
            end
            // report the best tour, one city per item
            ets_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (o_last) begin
                        n_state = ets_pkg::ST_IDLE;
                    end else begin
                        n_k = r_k + CNT_W'(1);
                    end
                end
            end
            default: n_state = ets_pkg::ST_IDLE;
        endcase
    end

    // Result payload
    assign o_best_cost = r_best;
    assign o_found     = r_found;
    assign o_city      = r_found ? r_best_tour[r_k[CITY_W-1:0]] : '0;
    assign o_last      = !r_found || (r_k == w_nlast);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ets_pkg::ST_IDLE;
            r_found  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_k      <= '0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_best   <= ets_pkg::COST_W'(ets_pkg::CEILING_RESET);
            r_sum    <= '0;
            for (int i = 0; i < NC; i++) begin
                r_tour[i]      <= CITY_W'(i);
                r_best_tour[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_found     <= n_found;
            r_rd_vld    <= n_rd_vld;
            r_k         <= n_k;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_best      <= n_best;
            r_sum       <= n_sum;
            r_tour      <= n_tour;
            r_best_tour <= n_best_tour;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_prev <= n_prev;
    end

    // Assertions
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("result offered while accepting items");

    a_clear_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> o_last)
        else $error("not-found report is more than one item");

    a_cost_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ets_pkg::ST_COST) |-> ((r_k != '0) && (r_k <= r_ncity)))
        else $error("edge index out of tour");

    a_pivot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ets_pkg::ST_FINDJ) |-> (r_hi > r_lo))
        else $error("swap search passed the pivot");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("not ready after final result item");

endmodule

`default_nettype wire

[src/ets_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the weight matrix of the tour search core.
`default_nettype none

module ets_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for exhaustive_tour_search_core: weight matrix loads, tour searches
// under several city counts and ceilings, randomized handshake pacing and a long sink stall.
// Depends on ets_pkg and the core RTL.
module tb;

    // One input item: a matrix weight load or a solve request
    typedef struct packed {
        logic                                   kind;
        logic [ets_pkg::CITY_W-1:0]             from_city;
        logic [ets_pkg::CITY_W-1:0]             to_city;
        logic signed [ets_pkg::WEIGHT_BITS-1:0] weight;
    } t_mat_item;

    // One reported step of the best tour
    typedef struct packed {
        logic signed [ets_pkg::COST_W-1:0] cost;
        logic [ets_pkg::CITY_W-1:0]        city;
        logic                              found;
        logic                              last;
    } t_tour_step;

    logic                                   i_clk       = 1'b0;
    logic                                   i_rst_n     = 1'b0;
    logic                                   i_cfg_we    = 1'b0;
    logic [ets_pkg::CFG_IDX_W-1:0]          i_cfg_idx   = '0;
    logic [ets_pkg::COST_W-1:0]             i_cfg_data  = '0;
    logic                                   i_in_valid  = 1'b0;
    logic                                   o_in_ready;
    logic                                   i_kind      = 1'b0;
    logic [ets_pkg::CITY_W-1:0]             i_from_city = '0;
    logic [ets_pkg::CITY_W-1:0]             i_to_city   = '0;
    logic signed [ets_pkg::WEIGHT_BITS-1:0] i_weight    = '0;
    logic                                   o_out_valid;
    logic                                   i_out_ready = 1'b0;
    logic signed [ets_pkg::COST_W-1:0]      o_best_cost;
    logic [ets_pkg::CITY_W-1:0]             o_city;
    logic                                   o_found;
    logic                                   o_last;

    // Items waiting for the driver, tour steps waiting for the sink
    t_mat_item  cmd_q[$];
    t_tour_step tour_q[$];

    // Shadow of the block's matrix and registers
    logic signed [ets_pkg::WEIGHT_BITS-1:0] wmat [ets_pkg::MAX_CITIES][ets_pkg::MAX_CITIES];
    logic [ets_pkg::CC_W-1:0]          cities_cfg  = ets_pkg::CC_W'(8);
    logic signed [ets_pkg::COST_W-1:0] ceiling_cfg = ets_pkg::COST_W'(ets_pkg::CEILING_RESET);

    int  items_planned = 0;
    int  items_taken   = 0;
    int  mismatch_cnt  = 0;
    bit  in_taken      = 1'b0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;
    logic [1:0] pace;

    // Pacing: sparse sender gaps, sink mostly stalled; then the reverse; then none
    assign pace = (items_taken < 110) ? 2'd0 : (items_taken < 185) ? 2'd1 : 2'd2;

    always #5 i_clk = ~i_clk;

    exhaustive_tour_search_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_from_city (i_from_city),
        .i_to_city   (i_to_city),
        .i_weight    (i_weight),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_best_cost (o_best_cost),
        .o_city      (o_city),
        .o_found     (o_found),
        .o_last      (o_last)
    );

    // Apply one item to the shadow state; a solve walks every tour from city 0
    function automatic void predict_best_tour(t_mat_item it);
        int n, i, j;
        logic [ets_pkg::CITY_W-1:0] order [ets_pkg::MAX_CITIES];
        logic [ets_pkg::CITY_W-1:0] keep  [ets_pkg::MAX_CITIES];
        logic [ets_pkg::CITY_W-1:0] t;
        logic signed [ets_pkg::COST_W-1:0] cost, best;
        longint sum;
        bit hit, more;
        t_tour_step r;
        if (it.kind == ets_pkg::KIND_LOAD) begin
            wmat[it.from_city][it.to_city] = it.weight;
            return;
        end
        n = cities_cfg;
        if (n < ets_pkg::MIN_CITIES) n = ets_pkg::MIN_CITIES;
        if (n > ets_pkg::MAX_CITIES) n = ets_pkg::MAX_CITIES;
        for (i = 0; i < ets_pkg::MAX_CITIES; i++) begin
            order[i] = ets_pkg::CITY_W'(i);
            keep[i]  = '0;
        end
        best = ceiling_cfg;
        hit  = 1'b0;
        more = 1'b1;
        while (more) begin
            // closed cycle, return edge included, clamped to the cost range
            sum = 0;
            for (i = 0; i < n; i++) begin
                sum = sum + wmat[order[i]][order[(i + 1) % n]];
            end
            if (sum > ets_pkg::COST_MAX) begin
                cost = ets_pkg::COST_W'(ets_pkg::COST_MAX);
            end else if (sum < ets_pkg::COST_MIN) begin
                cost = ets_pkg::COST_W'(ets_pkg::COST_MIN);
            end else begin
                cost = ets_pkg::COST_W'(sum);
            end
            // strictly cheaper only: ties keep the earlier tour
            if (cost < best) begin
                best = cost;
                keep = order;
                hit  = 1'b1;
            end
            // next lexicographic order of positions 1..n-1
            i = n - 1;
            while (i > 1 && order[i - 1] >= order[i]) i--;
            if (i <= 1) begin
                more = 1'b0;
            end else begin
                j = n - 1;
                while (order[j] <= order[i - 1]) j--;
                t = order[i - 1];
                order[i - 1] = order[j];
                order[j] = t;
                j = n - 1;
                while (i < j) begin
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                    i++;
                    j--;
                end
            end
        end
        if (!hit) begin
            r.cost  = best;
            r.city  = '0;
            r.found = 1'b0;
            r.last  = 1'b1;
            tour_q.insert(tour_q.size(), r);
        end else begin
            for (i = 0; i < n; i++) begin
                r.cost  = best;
                r.city  = keep[i];
                r.found = 1'b1;
                r.last  = (i == n - 1);
                tour_q.insert(tour_q.size(), r);
            end
        end
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%s", msg);
    endfunction

    function automatic int rand_weight();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 32767;
        if (roll == 1) return -32768;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic void queue_item(logic kind, int f, int t, int w);
        t_mat_item it;
        it.kind      = kind;
        it.from_city = ets_pkg::CITY_W'(f);
        it.to_city   = ets_pkg::CITY_W'(t);
        it.weight    = ets_pkg::WEIGHT_BITS'(w);
        cmd_q.insert(cmd_q.size(), it);
        items_planned++;
    endfunction

    // Solve payload fields are don't-care; randomize them anyway
    function automatic void queue_solve();
        queue_item(ets_pkg::KIND_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7),
                   rand_weight());
    endfunction

    function automatic void queue_rand_load();
        queue_item(ets_pkg::KIND_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                   rand_weight());
    endfunction

    // Register write; only called while the block is idle
    task automatic write_reg(input logic [ets_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ets_pkg::COST_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == ets_pkg::CFG_CITY_COUNT) begin
            cities_cfg = data[ets_pkg::CC_W-1:0];
        end else begin
            ceiling_cfg = data;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued item is taken and every tour step has come back
    task automatic drain_all();
        while (items_taken != items_planned || tour_q.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Driver: offer the next item once the current one is taken
    always @(negedge i_clk) begin : drive_items
        t_mat_item it;
        bit gap;
        gap = (pace == 2'd0) ? ($urandom_range(0, 99) < 16) :
              (pace == 2'd1) ? ($urandom_range(0, 99) < 84) : 1'b0;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (cmd_q.size() > 0 && !gap) begin
                it = cmd_q.pop_front();
                i_kind      <= it.kind;
                i_from_city <= it.from_city;
                i_to_city   <= it.to_city;
                i_weight    <= it.weight;
                i_in_valid  <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Sink: paced ready, plus one long hold-off while items are still queued
    always @(negedge i_clk) begin : drive_ready
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && pace == 2'd2 && o_out_valid && cmd_q.size() > 0) begin
            hold_left   <= 400;
            hold_done   <= 1'b1;
            i_out_ready <= 1'b0;
        end else if (pace == 2'd0) begin
            i_out_ready <= ($urandom_range(0, 99) >= 84);
        end else if (pace == 2'd1) begin
            i_out_ready <= ($urandom_range(0, 99) >= 16);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: predict on accepted items, check accepted tour steps
    always @(posedge i_clk) begin : watch
        t_mat_item  seen;
        t_tour_step want;
        if (i_rst_n) begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                seen.kind      = i_kind;
                seen.from_city = i_from_city;
                seen.to_city   = i_to_city;
                seen.weight    = i_weight;
                predict_best_tour(seen);
                items_taken <= items_taken + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (tour_q.size() == 0) begin
                    flag_mismatch($sformatf(
                        "unexpected result: cost %0d city %0d found %0b last %0b",
                        o_best_cost, o_city, o_found, o_last));
                end else begin
                    want = tour_q.pop_front();
                    if (o_best_cost !== want.cost || o_city !== want.city ||
                        o_found !== want.found || o_last !== want.last) begin
                        flag_mismatch($sformatf(
                            {"result mismatch: exp cost %0d city %0d found %0b last %0b,",
                             " got cost %0d city %0d found %0b last %0b"},
                            want.cost, want.city, want.found, want.last,
                            o_best_cost, o_city, o_found, o_last));
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin : stim
        int f, t, p, k, nitems, cc, pick;
        logic signed [ets_pkg::COST_W-1:0] ceil_v;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole matrix, then solve with the reset settings (8 cities, 32000)
        for (f = 0; f < ets_pkg::MAX_CITIES; f++) begin
            for (t = 0; t < ets_pkg::MAX_CITIES; t++) begin
                if (f == 7 && t == 0) queue_item(ets_pkg::KIND_LOAD, f, t, 32767);
                else if (f == 0 && t == 7) queue_item(ets_pkg::KIND_LOAD, f, t, -32768);
                else queue_item(ets_pkg::KIND_LOAD, f, t, rand_weight());
            end
        end
        queue_solve();
        drain_all();

        // Count below minimum, lowest ceiling: nothing beats it
        write_reg(ets_pkg::CFG_CITY_COUNT, ets_pkg::COST_W'(0));
        write_reg(ets_pkg::CFG_COST_CEILING, ets_pkg::COST_W'(ets_pkg::COST_MIN));
        queue_item(ets_pkg::KIND_LOAD, 0, 1, -32768);
        queue_item(ets_pkg::KIND_LOAD, 1, 0, -32768);
        queue_solve();
        drain_all();

        // Count of one, highest ceiling
        write_reg(ets_pkg::CFG_CITY_COUNT, ets_pkg::COST_W'(1));
        write_reg(ets_pkg::CFG_COST_CEILING, ets_pkg::COST_W'(ets_pkg::COST_MAX));
        queue_solve();
        drain_all();

        // All tours tie at 20: equal to the ceiling is not kept
        write_reg(ets_pkg::CFG_CITY_COUNT, ets_pkg::COST_W'(4));
        write_reg(ets_pkg::CFG_COST_CEILING, ets_pkg::COST_W'(20));
        for (f = 0; f < 4; f++) begin
            for (t = 0; t < 4; t++) begin
                if (f != t) queue_item(ets_pkg::KIND_LOAD, f, t, 5);
            end
        end
        queue_solve();
        drain_all();

        // Same ties under ceiling 21: the first (identity) tour wins
        write_reg(ets_pkg::CFG_COST_CEILING, ets_pkg::COST_W'(21));
        queue_solve();
        drain_all();

        // Largest weights on a three-city tour
        write_reg(ets_pkg::CFG_CITY_COUNT, ets_pkg::COST_W'(3));
        write_reg(ets_pkg::CFG_COST_CEILING, ets_pkg::COST_W'(ets_pkg::COST_MAX));
        for (f = 0; f < 3; f++) begin
            for (t = 0; t < 3; t++) begin
                if (f != t) queue_item(ets_pkg::KIND_LOAD, f, t, 32767);
            end
        end
        queue_solve();
        drain_all();

        // Random phases; a count above the maximum and count 7 get a single solve each
        p = 0;
        while (items_planned < 260) begin
            cc = (p == 0) ? 15 : (p == 4) ? 7 : $urandom_range(0, 6);
            pick = $urandom_range(0, 3);
            if (pick == 0) ceil_v = ets_pkg::COST_W'(ets_pkg::COST_MAX);
            else if (pick == 1) ceil_v = ets_pkg::COST_W'($urandom);
            else if (pick == 2) ceil_v = ets_pkg::COST_W'(int'($urandom_range(0, 80000)) - 40000);
            else ceil_v = ets_pkg::COST_W'(int'($urandom_range(0, 2000)) - 1000);
            write_reg(ets_pkg::CFG_CITY_COUNT,
                      ets_pkg::COST_W'({$urandom_range(0, 32767), 4'(cc)}));
            write_reg(ets_pkg::CFG_COST_CEILING, ceil_v);
            nitems = $urandom_range(6, 16);
            for (k = 0; k < nitems; k++) begin
                if (cc >= 7) begin
                    if (k == nitems - 1) queue_solve();
                    else queue_rand_load();
                end else if ($urandom_range(0, 3) == 0) begin
                    queue_solve();
                end else begin
                    queue_rand_load();
                end
            end
            drain_all();
            p++;
        end

        if (mismatch_cnt == 0 && tour_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
